>>> design/ipv6hc_pkg.sv
// Shared constants and types for the IPv6 header checker.
package ipv6hc_pkg;

  // Bad-address table size and derived widths
  localparam int BAD_ENTRIES = 16;
  localparam int BAD_W       = (BAD_ENTRIES > 1) ? $clog2(BAD_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(BAD_ENTRIES + 1);

  // Header geometry
  localparam logic [15:0] HDR_BYTES  = 16'd40;
  localparam logic [3:0]  IP_VERSION = 4'd6;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_OFFSET = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BAD_COUNT     = 2'd1;

  // Input function codes
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  // Table half select
  localparam logic HALF_UPPER = 1'b0;

  typedef enum logic [2:0] {
    DROP_NONE    = 3'd0,
    DROP_SHORT   = 3'd1,
    DROP_VERSION = 3'd2,
    DROP_PAYLOAD = 3'd3,
    DROP_SOURCE  = 3'd4
  } drop_reason_t;

  // Table write beat
  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic        half;
    logic [63:0] word;
  } tbl_wr_t;

  // Source lookup request from the parser
  typedef struct packed {
    logic         start;
    logic [127:0] src;
  } lkup_req_t;

  // Source lookup status back to the parser
  typedef struct packed {
    logic busy;
    logic hit;
  } lkup_sts_t;

endpackage

>>> design/ipv6hc_bad_table.sv
// Bad-address table memories and the sequential source scan.
module ipv6hc_bad_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [4:0]                   bad_count,
  input  ipv6hc_pkg::tbl_wr_t          tbl_wr,
  input  ipv6hc_pkg::lkup_req_t        req,
  output ipv6hc_pkg::lkup_sts_t        sts
);

  // Upper and lower address halves, one entry per row
  logic [63:0] mem_hi [ipv6hc_pkg::BAD_ENTRIES];
  logic [63:0] mem_lo [ipv6hc_pkg::BAD_ENTRIES];

  logic [63:0] rd_hi_r;
  logic [63:0] rd_lo_r;
  logic        rd_first_r;
  logic        rd_v_r;
  logic        w0_hi_r;
  logic        w0_lo_r;
  logic        busy_r;
  logic        hit_r;
  logic [127:0] src_r;
  logic [ipv6hc_pkg::CNT_W-1:0] idx_r;
  logic [ipv6hc_pkg::CNT_W-1:0] used;
  logic [ipv6hc_pkg::BAD_W-1:0] raddr;
  logic [ipv6hc_pkg::BAD_W-1:0] waddr;
  logic        wr_ok;
  logic        issue;
  logic [63:0] cmp_hi;
  logic [63:0] cmp_lo;

  // Entries in use, clamped to the table size
  always_comb begin
    if (32'(bad_count) > ipv6hc_pkg::BAD_ENTRIES) begin
      used = ipv6hc_pkg::CNT_W'(ipv6hc_pkg::BAD_ENTRIES);
    end else begin
      used = ipv6hc_pkg::CNT_W'(bad_count);
    end
  end

  assign wr_ok = tbl_wr.we && (32'(tbl_wr.idx) < ipv6hc_pkg::BAD_ENTRIES);
  assign waddr = ipv6hc_pkg::BAD_W'(tbl_wr.idx);
  assign raddr = idx_r[ipv6hc_pkg::BAD_W-1:0];
  assign issue = busy_r && (idx_r < used);

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      if (tbl_wr.half == ipv6hc_pkg::HALF_UPPER) begin
        mem_hi[waddr] <= tbl_wr.word;
      end else begin
        mem_lo[waddr] <= tbl_wr.word;
      end
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_hi_r    <= mem_hi[raddr];
    rd_lo_r    <= mem_lo[raddr];
    rd_first_r <= (idx_r == '0);
  end

  // Entry zero reads as all ones until each half is written
  assign cmp_hi = (rd_first_r && !w0_hi_r) ? '1 : rd_hi_r;
  assign cmp_lo = (rd_first_r && !w0_lo_r) ? '1 : rd_lo_r;

  // Scan sequencer: issue one entry a cycle, compare it in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rd_v_r  <= 1'b0;
      hit_r   <= 1'b0;
      w0_hi_r <= 1'b0;
      w0_lo_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (wr_ok && (tbl_wr.idx == 4'd0)) begin
        if (tbl_wr.half == ipv6hc_pkg::HALF_UPPER) begin
          w0_hi_r <= 1'b1;
        end else begin
          w0_lo_r <= 1'b1;
        end
      end
      if (req.start) begin
        busy_r <= (used != '0);
        idx_r  <= '0;
        rd_v_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (busy_r) begin
        rd_v_r <= issue;
        if (issue) begin
          idx_r <= idx_r + ipv6hc_pkg::CNT_W'(1);
        end
        if (rd_v_r && (cmp_hi == src_r[127:64]) && (cmp_lo == src_r[63:0])) begin
          hit_r <= 1'b1;
        end
        if (!issue && !rd_v_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Source under test
  always_ff @(posedge clk) begin
    if (req.start) begin
      src_r <= req.src;
    end
  end

  assign sts.busy = busy_r;
  assign sts.hit  = hit_r;

endmodule

>>> design/ipv6hc_parse.sv
// Header field capture, verdict logic, totals and result register.
module ipv6hc_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             header_offset,
  input  logic                   byte_take,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output ipv6hc_pkg::lkup_req_t  req,
  input  ipv6hc_pkg::lkup_sts_t  sts,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   out_accepted,
  output logic [2:0]             out_drop_reason,
  output logic [15:0]            out_kept_length,
  output logic                   out_was_trimmed,
  output logic [7:0]             out_next_header,
  output logic [31:0]            out_passed_count,
  output logic [31:0]            out_dropped_count
);

  logic [15:0] pos_r;
  logic [3:0]  ver_r,  ver_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  nh_r,   nh_nxt;
  logic [63:0] src0_r, src0_nxt;
  logic [63:0] src1_r, src1_nxt;
  logic        checked_r;
  logic [31:0] pass_r;
  logic [31:0] drop_r;

  logic        out_valid_r;
  logic        out_acc_r;
  logic [2:0]  out_reason_r;
  logic [15:0] out_kept_r;
  logic        out_trim_r;
  logic [7:0]  out_nh_r;

  logic [15:0] off16;
  logic [15:0] hpos;
  logic [5:0]  hs;
  logic        in_hdr;
  logic [15:0] total;
  logic [15:0] hdr_end;
  logic        is_short;
  logic [15:0] pay_avail;
  logic [16:0] kept_sum;
  logic [15:0] kept;
  ipv6hc_pkg::drop_reason_t reason;

  assign off16  = {8'd0, header_offset};
  assign hpos   = pos_r - off16;
  assign hs     = hpos[5:0];
  assign in_hdr = (pos_r >= off16) && (hpos < ipv6hc_pkg::HDR_BYTES);

  // Header field capture
  always_comb begin
    ver_nxt  = ver_r;
    plen_nxt = plen_r;
    nh_nxt   = nh_r;
    src0_nxt = src0_r;
    src1_nxt = src1_r;
    if (byte_take && in_hdr) begin
      if (hs == 6'd0) begin
        ver_nxt = data_byte[7:4];
      end else if (hs == 6'd4) begin
        plen_nxt = {data_byte, plen_r[7:0]};
      end else if (hs == 6'd5) begin
        plen_nxt = {plen_r[15:8], data_byte};
      end else if (hs == 6'd6) begin
        nh_nxt = data_byte;
      end else if ((hs >= 6'd8) && (hs < 6'd24)) begin
        if (hs[4]) begin
          src1_nxt = {src1_r[55:0], data_byte};
        end else begin
          src0_nxt = {src0_r[55:0], data_byte};
        end
      end
    end
  end

  // Kick off the table scan on the last source byte
  assign req.start = byte_take && in_hdr && (hs == 6'd23);
  assign req.src   = {src0_r, src1_nxt};

  // Verdict
  assign total     = (pos_r == ipv6hc_pkg::LEN_MAX) ? ipv6hc_pkg::LEN_MAX : pos_r + 16'd1;
  assign hdr_end   = off16 + ipv6hc_pkg::HDR_BYTES;
  assign is_short  = total < hdr_end;
  assign pay_avail = total - hdr_end;
  assign kept_sum  = {1'b0, hdr_end} + {1'b0, plen_nxt};
  assign kept      = kept_sum[16] ? ipv6hc_pkg::LEN_MAX : kept_sum[15:0];

  always_comb begin
    if (is_short) begin
      reason = ipv6hc_pkg::DROP_SHORT;
    end else if (ver_nxt != ipv6hc_pkg::IP_VERSION) begin
      reason = ipv6hc_pkg::DROP_VERSION;
    end else if (plen_nxt > pay_avail) begin
      reason = ipv6hc_pkg::DROP_PAYLOAD;
    end else if (checked_r && sts.hit) begin
      reason = ipv6hc_pkg::DROP_SOURCE;
    end else begin
      reason = ipv6hc_pkg::DROP_NONE;
    end
  end

  // Per-packet state and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ver_r     <= '0;
      plen_r    <= '0;
      nh_r      <= '0;
      src0_r    <= '0;
      src1_r    <= '0;
      checked_r <= 1'b0;
      pass_r    <= '0;
      drop_r    <= '0;
    end else if (byte_take) begin
      if (last_byte) begin
        pos_r     <= '0;
        ver_r     <= '0;
        plen_r    <= '0;
        nh_r      <= '0;
        src0_r    <= '0;
        src1_r    <= '0;
        checked_r <= 1'b0;
        if (reason == ipv6hc_pkg::DROP_NONE) begin
          pass_r <= pass_r + 32'd1;
        end else begin
          drop_r <= drop_r + 32'd1;
        end
      end else begin
        pos_r  <= total;
        ver_r  <= ver_nxt;
        plen_r <= plen_nxt;
        nh_r   <= nh_nxt;
        src0_r <= src0_nxt;
        src1_r <= src1_nxt;
        if (req.start) begin
          checked_r <= 1'b1;
        end
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (byte_take && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (byte_take && last_byte) begin
      out_acc_r    <= (reason == ipv6hc_pkg::DROP_NONE);
      out_reason_r <= reason;
      out_kept_r   <= (reason == ipv6hc_pkg::DROP_NONE) ? kept : 16'd0;
      out_trim_r   <= (reason == ipv6hc_pkg::DROP_NONE) && (plen_nxt < pay_avail);
      out_nh_r     <= nh_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_drop_reason   = out_reason_r;
  assign out_kept_length   = out_kept_r;
  assign out_was_trimmed   = out_trim_r;
  assign out_next_header   = out_nh_r;
  assign out_passed_count  = pass_r;
  assign out_dropped_count = drop_r;

endmodule

>>> design/ipv6_header_checker_unit.sv
// Top level of the IPv6 header checker.
// Packet bytes (func 0) and bad-address table writes (func 1) share the input
// channel. When the last source-address byte (header byte 23 after the
// offset) is taken, the input stalls (not at all when bad_count is 0) while
// the entries in use, bad_count clamped to the table size, are scanned one
// entry per cycle through the table's single registered read port. One
// result beat follows each last packet byte, in the next cycle, from an
// output register; further bytes are taken while it waits, and only a last
// byte is held off while a result is still stalled. Table entry 0 reads as
// all ones until written; other entries must be written before they are put
// in use by bad_count. Configuration writes take effect at once.
module ipv6_header_checker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipv6hc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ipv6hc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  input  logic [3:0]                        in_entry_index,
  input  logic                              in_entry_half,
  input  logic [63:0]                       in_entry_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [2:0]                        out_drop_reason,
  output logic [15:0]                       out_kept_length,
  output logic                              out_was_trimmed,
  output logic [7:0]                        out_next_header,
  output logic [31:0]                       out_passed_count,
  output logic [31:0]                       out_dropped_count
);

  logic [7:0] header_offset_r;
  logic [4:0] bad_count_r;
  logic       beat;
  logic       byte_take;
  ipv6hc_pkg::tbl_wr_t   tbl_wr;
  ipv6hc_pkg::lkup_req_t req;
  ipv6hc_pkg::lkup_sts_t sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_offset_r <= 8'd0;
      bad_count_r     <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        ipv6hc_pkg::REG_HEADER_OFFSET: header_offset_r <= cfg_data[7:0];
        ipv6hc_pkg::REG_BAD_COUNT:     bad_count_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Hold input during a scan, and hold a last byte while the result is blocked
  assign in_stall = sts.busy ||
                    (out_valid && out_stall && (in_func == ipv6hc_pkg::FUNC_BYTE) &&
                     in_last_byte);

  assign beat      = in_valid && !in_stall;
  assign byte_take = beat && (in_func == ipv6hc_pkg::FUNC_BYTE);

  assign tbl_wr.we   = beat && (in_func == ipv6hc_pkg::FUNC_TABLE);
  assign tbl_wr.idx  = in_entry_index;
  assign tbl_wr.half = in_entry_half;
  assign tbl_wr.word = in_entry_word;

  ipv6hc_bad_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .bad_count (bad_count_r),
    .tbl_wr    (tbl_wr),
    .req       (req),
    .sts       (sts)
  );

  ipv6hc_parse u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .header_offset     (header_offset_r),
    .byte_take         (byte_take),
    .data_byte         (in_data_byte),
    .last_byte         (in_last_byte),
    .req               (req),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_drop_reason   (out_drop_reason),
    .out_kept_length   (out_kept_length),
    .out_was_trimmed   (out_was_trimmed),
    .out_next_header   (out_next_header),
    .out_passed_count  (out_passed_count),
    .out_dropped_count (out_dropped_count)
  );

endmodule

>>> design/ipv6hc_checker.sv
// Port-level assertions for the IPv6 header checker, bound to the top level.
module ipv6hc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic [2:0]  out_drop_reason,
  input logic [15:0] out_kept_length,
  input logic        out_was_trimmed,
  input logic [31:0] out_passed_count,
  input logic [31:0] out_dropped_count
);

  // A stalled result beat holds its verdict and totals
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted) &&
      $stable(out_drop_reason) && $stable(out_passed_count) &&
      $stable(out_dropped_count))
    else $error("result beat changed while stalled");

  // Accepted verdict carries no reason and at least a full header length
  a_pass_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_drop_reason == ipv6hc_pkg::DROP_NONE &&
      out_kept_length >= ipv6hc_pkg::HDR_BYTES)
    else $error("accepted beat with bad fields");

  // Dropped verdict carries a reason and no kept length
  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_drop_reason != ipv6hc_pkg::DROP_NONE &&
      out_kept_length == 16'd0 && !out_was_trimmed)
    else $error("dropped beat with bad fields");

  // A last byte is never taken while a result is blocked
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid && (in_func == ipv6hc_pkg::FUNC_BYTE) &&
      in_last_byte |-> in_stall)
    else $error("last byte taken over a blocked result");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ipv6_header_checker_unit ipv6hc_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_func           (in_func),
  .in_last_byte      (in_last_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_accepted      (out_accepted),
  .out_drop_reason   (out_drop_reason),
  .out_kept_length   (out_kept_length),
  .out_was_trimmed   (out_was_trimmed),
  .out_passed_count  (out_passed_count),
  .out_dropped_count (out_dropped_count)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv6_header_checker_unit: directed and random packets.
module tb_top;
  import ipv6hc_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_ITEMS  = 200;
  localparam int HDR_LEN      = int'(HDR_BYTES);
  localparam int LEN_SAT      = int'(LEN_MAX);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  // One verdict beat as seen on the result port
  typedef struct packed {
    logic         accepted;
    drop_reason_t reason;
    logic [15:0]  kept_length;
    logic         was_trimmed;
    logic [7:0]   next_header;
    logic [31:0]  passed;
    logic [31:0]  dropped;
  } verdict_t;

  // Header parser / table lookup predictor and the queue of verdicts it owes
  class header_verdicts;
    logic [7:0]  hdr_offset;
    logic [4:0]  bad_count;
    int          pos;
    logic [3:0]  ip_ver;
    logic [15:0] pay_len;
    logic [7:0]  nxt_hdr;
    logic [63:0] src [2];
    bit          src_bad;
    logic [63:0] bad_tbl [2*BAD_ENTRIES];
    logic [31:0] n_pass;
    logic [31:0] n_drop;
    verdict_t    due_verdicts [$];
    int          n_bad;

    function new();
      hdr_offset = '0;
      bad_count  = 5'd1;
      pos        = 0;
      ip_ver     = '0;
      pay_len    = '0;
      nxt_hdr    = '0;
      src[0]     = '0;
      src[1]     = '0;
      src_bad    = 1'b0;
      foreach (bad_tbl[i]) bad_tbl[i] = '0;
      // entry 0 comes out of reset as the all-ones address
      bad_tbl[0] = '1;
      bad_tbl[1] = '1;
      n_pass     = '0;
      n_drop     = '0;
      n_bad      = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_HEADER_OFFSET) hdr_offset = data;
      else if (addr == REG_BAD_COUNT) bad_count = data[4:0];
    endfunction

    // counts above the table size use the whole table
    function int used_entries();
      return (bad_count > BAD_ENTRIES) ? BAD_ENTRIES : int'(bad_count);
    endfunction

    function void take_beat(logic func, logic [7:0] b, logic last, logic [3:0] idx,
                            logic half, logic [63:0] word);
      int       h;
      int       total;
      int       present;
      verdict_t v;
      if (func == FUNC_TABLE) begin
        if (idx < BAD_ENTRIES) bad_tbl[2*idx + half] = word;
        return;
      end
      // capture header fields
      h = pos - hdr_offset;
      if (pos >= hdr_offset && h < HDR_LEN) begin
        if (h == 0) ip_ver = b[7:4];
        else if (h == 4) pay_len[15:8] = b;
        else if (h == 5) pay_len[7:0] = b;
        else if (h == 6) nxt_hdr = b;
        else if (h >= 8 && h < 24) begin
          src[(h-8)/8] = {src[(h-8)/8][55:0], b};
          // lookup against the table as it stands when the source completes
          if (h == 23) begin
            src_bad = 1'b0;
            for (int i = 0; i < used_entries(); i++) begin
              if (bad_tbl[2*i] == src[0] && bad_tbl[2*i+1] == src[1]) src_bad = 1'b1;
            end
          end
        end
      end
      total = (pos < LEN_SAT) ? pos + 1 : LEN_SAT;
      if (!last) begin
        pos = total;
        return;
      end
      // verdict: first failing check wins
      v = '0;
      v.reason = DROP_NONE;
      v.next_header = nxt_hdr;
      present = total - hdr_offset - HDR_LEN;
      if (total < hdr_offset + HDR_LEN) v.reason = DROP_SHORT;
      else if (ip_ver != IP_VERSION) v.reason = DROP_VERSION;
      else if (pay_len > present) v.reason = DROP_PAYLOAD;
      else if (src_bad) v.reason = DROP_SOURCE;
      else begin
        v.accepted    = 1'b1;
        v.kept_length = 16'(hdr_offset + HDR_LEN + pay_len);
        v.was_trimmed = (pay_len < present);
      end
      if (v.accepted) n_pass++;
      else n_drop++;
      v.passed  = n_pass;
      v.dropped = n_drop;
      due_verdicts.insert(due_verdicts.size(), v);
      pos     = 0;
      ip_ver  = '0;
      pay_len = '0;
      nxt_hdr = '0;
      src[0]  = '0;
      src[1]  = '0;
      src_bad = 1'b0;
    endfunction

    function void report(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        n_bad++;
      end
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        $display("%0t: verdict beat with none expected, actual %0h", $time, got);
        n_bad++;
        return;
      end
      want = due_verdicts.pop_front();
      report("accepted", want.accepted, got.accepted);
      report("drop_reason", want.reason, got.reason);
      report("kept_length", want.kept_length, got.kept_length);
      report("was_trimmed", want.was_trimmed, got.was_trimmed);
      report("next_header", want.next_header, got.next_header);
      report("passed_count", want.passed, got.passed);
      report("dropped_count", want.dropped, got.dropped);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_func;
  logic [7:0]            in_data_byte;
  logic                  in_last_byte;
  logic [3:0]            in_entry_index;
  logic                  in_entry_half;
  logic [63:0]           in_entry_word;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_accepted;
  logic [2:0]            out_drop_reason;
  logic [15:0]           out_kept_length;
  logic                  out_was_trimmed;
  logic [7:0]            out_next_header;
  logic [31:0]           out_passed_count;
  logic [31:0]           out_dropped_count;

  header_verdicts verdicts;
  bit             quiet;
  bit             table_noise;
  bit             hold_req;
  int             n_items;

  ipv6_header_checker_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .in_entry_index    (in_entry_index),
    .in_entry_half     (in_entry_half),
    .in_entry_word     (in_entry_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_drop_reason   (out_drop_reason),
    .out_kept_length   (out_kept_length),
    .out_was_trimmed   (out_was_trimmed),
    .out_next_header   (out_next_header),
    .out_passed_count  (out_passed_count),
    .out_dropped_count (out_dropped_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly short gaps, a few long ones; none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one input beat; returns once it has been taken
  task automatic send_beat(input logic func, input logic [7:0] b, input logic last,
                           input logic [3:0] idx, input logic half, input logic [63:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_data_byte   <= b;
    in_last_byte   <= last;
    in_entry_index <= idx;
    in_entry_half  <= half;
    in_entry_word  <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    verdicts.take_beat(func, b, last, idx, half, word);
    n_items++;
  endtask

  // packet byte fields are don't-care on a table write
  task automatic send_table_write(input logic [3:0] idx, input logic half,
                                  input logic [63:0] word);
    send_beat(FUNC_TABLE, $urandom, $urandom_range(0, 1), idx, half, word);
  endtask

  // one packet; clobber >= 0 rewrites that entry right after the source completes
  task automatic send_packet(input int offs, input logic [3:0] ver, input logic [15:0] plen,
                             input logic [7:0] nh, input logic [127:0] addr, input int len,
                             input int clobber);
    int         h;
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      h = p - offs;
      b = $urandom;
      if (h == 0) b[7:4] = ver;
      else if (h == 4) b = plen[15:8];
      else if (h == 5) b = plen[7:0];
      else if (h == 6) b = nh;
      else if (h >= 8 && h < 24) b = addr[127 - 8*(h-8) -: 8];
      if (table_noise && $urandom_range(0, 99) < 3)
        send_table_write($urandom_range(0, 15), $urandom, {$urandom, $urandom});
      send_beat(FUNC_BYTE, b, p == len - 1, $urandom, $urandom, {$urandom, $urandom});
      if (h == 23 && clobber >= 0)
        send_table_write(clobber, HALF_UPPER, ~verdicts.bad_tbl[2*clobber]);
    end
  endtask

  // let every owed verdict arrive, then cover a table scan still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdicts.due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, plus the two unused indexes which must be ignored
  task automatic program_regs(input logic [7:0] offs, input logic [4:0] cnt);
    logic [CFG_ADDR_W-1:0] addr [4];
    logic [CFG_DATA_W-1:0] data [4];
    logic [2:0]            junk;
    junk = $urandom;
    addr = '{REG_HEADER_OFFSET, REG_BAD_COUNT, REG_SPARE_2, REG_SPARE_3};
    data = '{offs, {junk, cnt}, $urandom, $urandom};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= addr[i];
      cfg_data <= data[i];
      @(posedge clk);
      verdicts.write_reg(addr[i], data[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: check taken beats, stall at random, long hold-off on request
  initial begin
    int       stall_left;
    int       hold_left;
    verdict_t got;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.accepted    = out_accepted;
        got.reason      = drop_reason_t'(out_drop_reason);
        got.kept_length = out_kept_length;
        got.was_trimmed = out_was_trimmed;
        got.next_header = out_next_header;
        got.passed      = out_passed_count;
        got.dropped     = out_dropped_count;
        verdicts.match_verdict(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = (!quiet && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
        out_stall <= (stall_left > 0);
      end
    end
  end

  // run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("ipv6_header_checker_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    logic [7:0]   offs;
    logic [4:0]   cnt;
    logic [3:0]   ver;
    logic [15:0]  plen;
    logic [7:0]   nh;
    logic [127:0] addr;
    logic [63:0]  word;
    int           len;
    int           present;
    int           used;
    int           r;
    int           phase;
    int           start;

    verdicts       = new();
    quiet          = 1'b0;
    table_noise    = 1'b0;
    hold_req       = 1'b0;
    n_items        = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_addr       <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_BYTE;
    in_data_byte   <= '0;
    in_last_byte   <= 1'b0;
    in_entry_index <= '0;
    in_entry_half  <= HALF_UPPER;
    in_entry_word  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: offset 0, entry 0 (all ones) in use
    send_packet(0, IP_VERSION, 16'h0000, 8'hFF, '1, HDR_LEN, -1);
    send_packet(0, IP_VERSION, 16'h0000, 8'h00, '0, HDR_LEN, -1);
    send_packet(0, IP_VERSION, 16'h0000, 8'h11, '0, 1, -1);
    send_packet(0, IP_VERSION, 16'h0000, 8'h22, '0, HDR_LEN - 1, -1);
    send_packet(0, 4'hF, 16'h0000, 8'h33, '0, HDR_LEN + 1, -1);
    send_packet(0, IP_VERSION, 16'hFFFF, 8'h44, '0, HDR_LEN, -1);
    send_packet(0, IP_VERSION, 16'h0003, 8'h55, '0, HDR_LEN + 7, -1);

    // fill the whole table; entry 1 all zeros, entry 15 split ones/zeros
    for (int k = 0; k < BAD_ENTRIES; k++) begin
      for (int hf = 0; hf < 2; hf++) begin
        word = {$urandom, $urandom};
        if (k == 1) word = '0;
        if (k == BAD_ENTRIES - 1) word = (hf == 0) ? '1 : '0;
        send_table_write(k, hf, word);
      end
    end
    wait_idle();
    program_regs(8'd0, 5'd16);
    addr = {verdicts.bad_tbl[2*(BAD_ENTRIES-1)], verdicts.bad_tbl[2*(BAD_ENTRIES-1)+1]};
    send_packet(0, IP_VERSION, 16'h0000, 8'h06, addr, HDR_LEN, -1);
    // overwriting the matched entry after the compare keeps the drop
    addr = {verdicts.bad_tbl[6], verdicts.bad_tbl[7]};
    send_packet(0, IP_VERSION, 16'h0000, 8'h11, addr, HDR_LEN + 2, 3);
    addr = {verdicts.bad_tbl[2], verdicts.bad_tbl[3]};
    send_packet(0, IP_VERSION, 16'h0000, 8'h3A, addr, HDR_LEN, -1);

    // largest offset, count beyond the table size
    wait_idle();
    program_regs(8'd255, 5'd31);
    addr = {verdicts.bad_tbl[14], verdicts.bad_tbl[15]};
    send_packet(255, IP_VERSION, 16'd5, 8'h2B, addr, 255 + HDR_LEN + 5, -1);
    send_packet(255, IP_VERSION, 16'd5, 8'h2C, {$urandom, $urandom, $urandom, $urandom},
                255 + HDR_LEN + 5, -1);
    send_packet(255, IP_VERSION, 16'd0, 8'h2D, '0, 255 + HDR_LEN - 1, -1);

    // empty table in use: a listed source passes
    wait_idle();
    program_regs(8'd0, 5'd0);
    addr = {verdicts.bad_tbl[0], verdicts.bad_tbl[1]};
    send_packet(0, IP_VERSION, 16'd1, 8'h3B, addr, HDR_LEN + 1, -1);

    // random phases, each under its own settings
    table_noise = 1'b1;
    n_items     = 0;
    phase       = 0;
    while (n_items < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        0:       offs = 8'd0;
        1:       offs = 8'd255;
        2:       offs = $urandom_range(1, 20);
        default: offs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 20);
      endcase
      case (phase % 6)
        0:       cnt = 5'd16;
        1:       cnt = 5'd0;
        2:       cnt = 5'd31;
        3:       cnt = 5'd1;
        4:       cnt = $urandom_range(2, 15);
        default: cnt = $urandom_range(17, 31);
      endcase
      program_regs(offs, cnt);
      quiet = (phase % 5 == 2);

      // receiver holds off while one-byte packets pile up behind it
      if (phase == 3) begin
        hold_req = 1'b1;
        repeat (12) send_packet(offs, IP_VERSION, 16'h0000, $urandom, '0, 1, -1);
      end

      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_table_write($urandom_range(0, 15), $urandom, {$urandom, $urandom});
        end else begin
          ver  = IP_VERSION;
          plen = $urandom_range(0, 16);
          nh   = $urandom;
          addr = {$urandom, $urandom, $urandom, $urandom};
          len  = offs + HDR_LEN + plen + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
          used = verdicts.used_entries();
          if (used > 0 && $urandom_range(0, 3) == 0) begin
            r    = $urandom_range(0, used - 1);
            addr = {verdicts.bad_tbl[2*r], verdicts.bad_tbl[2*r+1]};
            r    = 0;
          end
          if (r < 70) begin
            // well-formed
          end else if (r < 78) begin
            len = $urandom_range(1, offs + HDR_LEN - 1);
          end else if (r < 86) begin
            ver = $urandom;
          end else if (r < 93) begin
            present = len - offs - HDR_LEN;
            plen = ($urandom_range(0, 3) == 0) ? 16'hFFFF : present + $urandom_range(1, 3);
          end else begin
            ver  = $urandom;
            plen = $urandom;
            len  = $urandom_range(1, offs + 60);
          end
          send_packet(offs, ver, plen, nh, addr, len, -1);
        end
      end
      phase++;
    end

    quiet = 1'b0;
    wait_idle();
    if (verdicts.n_bad == 0) begin
      $display("ipv6_header_checker_unit: match");
    end else begin
      $display("ipv6_header_checker_unit: mismatch");
    end
    $finish;
  end

endmodule
